// File: rtl/rokl_pkg.sv
package rokl_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int KIND_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 5;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_PUSH   = 2'd0;
  localparam kind_t KIND_POP    = 2'd1;
  localparam kind_t KIND_DELETE = 2'd2;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_EMPTY     = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_FULL      = 2'd3;

  typedef struct packed {
    logic push;
    logic del;
  } cell_ctl_t;

endpackage

// File: rtl/rokl_cell.sv
module rokl_cell
  import rokl_pkg::*;
(
  input  logic                    clk,
  input  cell_ctl_t               ctl,
  input  logic                    occ,
  input  logic signed [KEY_W-1:0] key,
  input  logic signed [KEY_W-1:0] prev_data,
  input  logic signed [KEY_W-1:0] next_data,
  input  logic                    found_in,
  output logic                    found_out,
  output logic signed [KEY_W-1:0] data
);

  logic signed [KEY_W-1:0] data_r;
  logic signed [KEY_W-1:0] data_nxt;
  logic                    hit;

  assign hit       = occ && (data_r == key);
  assign found_out = found_in || hit;
  assign data      = data_r;

  always_comb begin
    data_nxt = data_r;
    case (1'b1)
      ctl.push: data_nxt = prev_data;
      ctl.del:  data_nxt = found_out ? next_data : data_r;
      default:  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: rtl/recency_ordered_key_list_unit.sv
// Channel   Ports                                        Handshake
// request   start, busy, in_kind, in_key                 start && !busy
// result    out_valid, out_value, out_status,            out_valid, one cycle
//           out_entry_count
//
// Each request is first latched and then executed, when every cell of the
// chain compares its key and shifts toward its neighbor; the result register
// strobes out_valid in the cycle after that.
// busy is high for the one execute cycle; a new request may be taken while the
// previous result is shown. Reset clears the entry count and the strobe; cell
// contents are left as they are. The receiver cannot stall.
module recency_ordered_key_list_unit
  import rokl_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [KIND_W-1:0]       in_kind,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  output logic signed [KEY_W-1:0] out_value,
  output logic [STATUS_W-1:0]     out_status,
  output logic [COUNT_W-1:0]      out_entry_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                    busy_r;
  kind_t                   kind_r;
  logic signed [KEY_W-1:0] key_r;
  logic [CNT_W-1:0]        fill_r;
  logic [CNT_W-1:0]        fill_nxt;
  logic                    out_valid_r;
  logic signed [KEY_W-1:0] out_value_r;
  logic signed [KEY_W-1:0] out_value_nxt;
  status_t                 out_status_r;
  status_t                 out_status_nxt;
  logic [CNT_W+COUNT_W-1:0] fill_ext;

  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    found;
  logic signed [KEY_W-1:0] back_data;
  cell_ctl_t               ctl;

  logic signed [KEY_W-1:0] cell_data [DEPTH];
  logic                    found_chain [DEPTH+1];

  assign accept = start && !busy_r;
  assign full   = (fill_r == CNT_W'(DEPTH));
  assign empty  = (fill_r == '0);
  assign found  = found_chain[DEPTH];

  assign ctl.push = busy_r && (kind_r == KIND_PUSH) && !full;
  assign ctl.del  = busy_r && (kind_r == KIND_DELETE);

  assign found_chain[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [KEY_W-1:0] prev_d;
    logic signed [KEY_W-1:0] next_d;
    if (i == 0) begin : g_first
      assign prev_d = key_r;
    end else begin : g_mid
      assign prev_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_inner
      assign next_d = cell_data[i+1];
    end
    rokl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occ       (CNT_W'(i) < fill_r),
      .key       (key_r),
      .prev_data (prev_d),
      .next_data (next_d),
      .found_in  (found_chain[i]),
      .found_out (found_chain[i+1]),
      .data      (cell_data[i])
    );
  end

  always_comb begin
    back_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (CNT_W'(i + 1) == fill_r) begin
        back_data = back_data | cell_data[i];
      end
    end
  end

  always_comb begin
    fill_nxt       = fill_r;
    out_value_nxt  = '0;
    out_status_nxt = ST_OK;
    case (kind_r)
      KIND_PUSH: begin
        if (full) begin
          out_status_nxt = ST_FULL;
        end else begin
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      KIND_POP: begin
        if (empty) begin
          out_status_nxt = ST_EMPTY;
        end else begin
          fill_nxt      = fill_r - CNT_W'(1);
          out_value_nxt = back_data;
        end
      end
      KIND_DELETE: begin
        if (found) begin
          fill_nxt = fill_r - CNT_W'(1);
        end else begin
          out_status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
        fill_nxt = fill_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (busy_r) begin
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= in_kind;
      key_r  <= in_key;
    end
    if (busy_r) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign fill_ext        = {{COUNT_W{1'b0}}, fill_r};
  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_status      = out_status_r;
  assign out_entry_count = fill_ext[COUNT_W-1:0];

  a_exec_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> out_valid_r)
    else $error("execute cycle not followed by result strobe");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_fail_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r != ST_OK)) |-> (out_value_r == '0))
    else $error("failed request returned nonzero value");

  a_fill_only_on_exec: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> $stable(fill_r))
    else $error("entry count changed outside execute cycle");

endmodule

// File: verif/tb_recency_ordered_key_list_unit.sv
module tb_recency_ordered_key_list_unit;
  import rokl_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int ROWS = 20;
  localparam int RANDOM_PER_PHASE = 465;
  localparam kind_t KIND_UNUSED = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [KEY_W-1:0] value;
    status_t                 status;
    logic [COUNT_W-1:0]      count;
  } list_reply_t;

  typedef struct packed {
    kind_t                   kind;
    logic signed [KEY_W-1:0] key;
    int                      reps;
    logic                    typed;
    logic signed [KEY_W-1:0] value;
    status_t                 status;
    logic [COUNT_W-1:0]      count;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  kind_t in_kind = KIND_PUSH;
  logic signed [KEY_W-1:0] in_key = '0;
  logic busy;
  logic out_valid;
  logic signed [KEY_W-1:0] out_value;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0] out_entry_count;

  logic signed [KEY_W-1:0] slots [LIST_DEPTH];
  int held = 0;
  list_reply_t replies_due [$];
  int mismatches = 0;
  int idle_pct = 0;

  stim_row_t script [ROWS] = '{
    '{KIND_POP,    32'sd0,          1,  1'b1, 32'sd0,  ST_EMPTY,     5'd0},
    '{KIND_DELETE, 32'sd5,          1,  1'b1, 32'sd0,  ST_NOT_FOUND, 5'd0},
    '{KIND_UNUSED, 32'sd0,          1,  1'b1, 32'sd0,  ST_OK,        5'd0},
    '{KIND_PUSH,   KEY_MIN,         1,  1'b1, 32'sd0,  ST_OK,        5'd1},
    '{KIND_POP,    32'sd0,          1,  1'b1, KEY_MIN, ST_OK,        5'd0},
    '{KIND_PUSH,   KEY_MAX,         1,  1'b1, 32'sd0,  ST_OK,        5'd1},
    '{KIND_PUSH,   -32'sd1,         1,  1'b0, 32'sd0,  ST_OK,        5'd0},
    '{KIND_PUSH,   32'sd0,          1,  1'b0, 32'sd0,  ST_OK,        5'd0},
    '{KIND_PUSH,   -32'sd1,         1,  1'b0, 32'sd0,  ST_OK,        5'd0},
    '{KIND_DELETE, -32'sd1,         1,  1'b1, 32'sd0,  ST_OK,        5'd3},
    '{KIND_DELETE, 32'sd12345,      1,  1'b1, 32'sd0,  ST_NOT_FOUND, 5'd3},
    '{KIND_POP,    -32'sd1,         1,  1'b1, KEY_MAX, ST_OK,        5'd2},
    '{KIND_UNUSED, KEY_MIN,         1,  1'b1, 32'sd0,  ST_OK,        5'd2},
    '{KIND_PUSH,   32'sh5555_5555,  14, 1'b0, 32'sd0,  ST_OK,        5'd0},
    '{KIND_PUSH,   32'shAAAA_AAAA,  1,  1'b1, 32'sd0,  ST_FULL,      5'd16},
    '{KIND_DELETE, 32'sd0,          1,  1'b0, 32'sd0,  ST_OK,        5'd0},
    '{KIND_PUSH,   32'shAAAA_AAAA,  1,  1'b0, 32'sd0,  ST_OK,        5'd0},
    '{KIND_DELETE, -32'sd1,         1,  1'b0, 32'sd0,  ST_OK,        5'd0},
    '{KIND_POP,    32'sd0,          15, 1'b0, 32'sd0,  ST_OK,        5'd0},
    '{KIND_POP,    32'sd0,          1,  1'b1, 32'sd0,  ST_EMPTY,     5'd0}
  };

  recency_ordered_key_list_unit #(
    .DEPTH(LIST_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_kind(in_kind),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_value(out_value),
    .out_status(out_status),
    .out_entry_count(out_entry_count)
  );

  always #2 clk = ~clk;

  function automatic list_reply_t step_list(kind_t kind, logic signed [KEY_W-1:0] key);
    list_reply_t r;
    int i;
    int hit;
    r.value = '0;
    r.status = ST_OK;
    case (kind)
      KIND_PUSH: begin
        if (held >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = held; i > 0; i--) slots[i] = slots[i-1];
          slots[0] = key;
          held++;
        end
      end
      KIND_POP: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          held--;
          r.value = slots[held];
        end
      end
      KIND_DELETE: begin
        hit = held;
        for (i = 0; i < held && hit == held; i++) if (slots[i] == key) hit = i;
        if (hit == held) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = hit; i + 1 < held; i++) slots[i] = slots[i+1];
          held--;
        end
      end
      default: begin
      end
    endcase
    r.count = COUNT_W'(held);
    return r;
  endfunction

  task automatic issue_request(input kind_t kind, input logic signed [KEY_W-1:0] key,
                               input logic typed, input list_reply_t typed_reply);
    list_reply_t due;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_key <= key;
    @(posedge clk);
    // hold the request until the block is free
    while (busy !== 1'b0) @(posedge clk);
    due = step_list(kind, key);
    if (typed) due = typed_reply;
    replies_due.push_back(due);
  endtask

  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(3))
      0, 1: k = $urandom;
      2: k = $signed(KEY_W'($urandom_range(7))) - 32'sd4;
      default: k = $urandom_range(1) ? KEY_MAX : KEY_MIN;
    endcase
    return k;
  endfunction

  always @(negedge clk) begin : check_replies
    list_reply_t head;
    if (rst_n && out_valid === 1'b1) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d count=%0d",
                 $time, out_value, out_status, out_entry_count);
        mismatches++;
      end else begin
        head = replies_due.pop_front();
        if (out_value !== head.value) begin
          $display("%0t: value expected %0d actual %0d", $time, head.value, out_value);
          mismatches++;
        end
        if (out_status !== head.status) begin
          $display("%0t: status expected %0d actual %0d", $time, head.status, out_status);
          mismatches++;
        end
        if (out_entry_count !== head.count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, head.count, out_entry_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int row;
    int rep;
    int phase;
    int n;
    int r;
    int push_bias;
    int guard;
    kind_t kind;
    logic signed [KEY_W-1:0] key;
    list_reply_t typed_reply;
    list_reply_t none;

    none = '0;
    push_bias = 50;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (row = 0; row < ROWS; row++) begin
      typed_reply.value = script[row].value;
      typed_reply.status = script[row].status;
      typed_reply.count = script[row].count;
      for (rep = 0; rep < script[row].reps; rep++)
        issue_request(script[row].kind, script[row].key, script[row].typed, typed_reply);
    end

    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 15 : (phase == 1) ? 88 : 0;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: push_bias = 20;
            1: push_bias = 50;
            default: push_bias = 80;
          endcase
        end
        r = $urandom_range(99);
        if (r < 3) kind = KIND_UNUSED;
        else if (r < 3 + push_bias * 97 / 100) kind = KIND_PUSH;
        else if ($urandom_range(1) == 1) kind = KIND_POP;
        else kind = KIND_DELETE;
        if (kind == KIND_DELETE && held > 0 && $urandom_range(9) < 6)
          key = slots[$urandom_range(held - 1)];
        else
          key = pick_key();
        issue_request(kind, key, 1'b0, none);
      end
    end

    start <= 1'b0;
    for (guard = 0; guard < 64 && replies_due.size() != 0; guard++) @(posedge clk);
    repeat (6) @(posedge clk);
    if (replies_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, replies_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
